// ===== rtl/core/fmf_pkg.sv =====
`default_nettype none

package fmf_pkg;

    // Identifier width and presence map word geometry
    localparam int ID_W         = 16;
    localparam int WORD_BITS    = 64;
    localparam int WORD_SHIFT   = 6;
    localparam int DEF_MAP_BITS = 256;

    typedef logic [ID_W-1:0] t_id;

endpackage

`default_nettype wire

// ===== rtl/core/fmf_ram.sv =====
`default_nettype none

module fmf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/first_missing_id_finder_unit.sv =====
`default_nettype none
// Channel  | Valid       | Ready       | Payload
// ---------+-------------+-------------+------------------------------
// input    | i_in_valid  | o_in_ready  | i_id_value, i_last_item
// result   | o_out_valid | i_out_ready | o_hole_value
//
// A non-last beat is accepted, then a read-modify-write marks at most one
// 64-bit word of the presence map RAM (one read port, one write port).
// A last beat adds a setup state, a read and a check state per scanned map word
// (ceil(min(count, MAP_BITS) / 64) words at most) and a handoff state.
// Reset clears the counter, base and per-word valid flags at once; no sweep.
// A held result stalls the next set at its handoff; input waits until it drains.

module first_missing_id_finder_unit #(
    parameter int MAP_BITS = fmf_pkg::DEF_MAP_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic signed [fmf_pkg::ID_W-1:0] i_id_value,
    input  wire logic                     i_last_item,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed [fmf_pkg::ID_W-1:0] o_hole_value
);

    import fmf_pkg::*;

    localparam int NWORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int CW     = $clog2(MAP_BITS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MARK = 3'd1;
    localparam logic [2:0] S_INIT = 3'd2;
    localparam logic [2:0] S_SRD  = 3'd3;
    localparam logic [2:0] S_SCK  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    t_id                   r_base;
    t_id                   r_count;
    logic [NWORDS-1:0]     r_wvalid;
    logic                  r_mark;
    logic                  r_last;
    logic [WAW-1:0]        r_mword;
    logic [WORD_SHIFT-1:0] r_mbit;
    logic [WAW-1:0]        r_word;
    logic [WAW-1:0]        r_last_word;
    logic [WORD_SHIFT-1:0] r_last_bit;
    t_id                   r_res;
    logic                  r_ovalid;
    t_id                   r_out;

    logic                  accept;
    logic                  load_out;
    logic [16:0]           off;
    logic [16:0]           off_word;
    logic                  off_in_map;
    logic [WAW-1:0]        ram_raddr;
    logic                  ram_we;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [WORD_BITS-1:0]  ram_rdata;
    logic [WORD_BITS-1:0]  word_data;
    logic [WORD_BITS-1:0]  occ;
    logic                  found;
    logic [WORD_SHIFT-1:0] idx;
    t_id                   hole_off;
    logic [CW-1:0]         bound;
    logic [CW-1:0]         bound_m1;

    assign accept   = i_in_valid && o_in_ready;
    assign load_out = (r_state == S_DONE) && (!r_ovalid || i_out_ready);

    // offset of the incoming id from the base, 17-bit two's complement
    assign off        = {i_id_value[ID_W-1], i_id_value} - {r_base[ID_W-1], r_base};
    assign off_word   = off >> WORD_SHIFT;
    assign off_in_map = !off[16] && (off < 17'(MAP_BITS));

    // search bound: min(count, MAP_BITS)
    assign bound    = (r_count < ID_W'(MAP_BITS)) ? r_count[CW-1:0] : CW'(MAP_BITS);
    assign bound_m1 = CW'(bound - 1'b1);

    // RAM read address: word of the incoming beat, or the scan word
    assign ram_raddr = (r_state == S_IDLE) ? off_word[WAW-1:0] : r_word;

    // mark write: unwritten words read as zero
    assign ram_we    = (r_state == S_MARK) && r_mark;
    assign ram_wdata = (r_wvalid[r_mword] ? ram_rdata : '0)
                     | (WORD_BITS'(1) << r_mbit);

    fmf_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_mword),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // first clear offset in the scanned word; base bit and bits past bound count as set
    assign word_data = r_wvalid[r_word] ? ram_rdata : '0;

    always_comb begin
        occ = '0;
        idx = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            occ[b] = word_data[b]
                   || ((r_word == '0) && (b == 0))
                   || ((r_word == r_last_word) && (WORD_SHIFT'(b) > r_last_bit));
        end
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!occ[b]) begin
                idx = WORD_SHIFT'(b);
            end
        end
    end

    assign found    = !(&occ);
    assign hole_off = (ID_W'(r_word) << WORD_SHIFT) | ID_W'(idx);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_MARK;
            S_MARK: n_state = r_last ? S_INIT : S_IDLE;
            S_INIT: n_state = (bound < CW'(2)) ? S_DONE : S_SRD;
            S_SRD:  n_state = S_SCK;
            S_SCK:  n_state = (found || (r_word == r_last_word)) ? S_DONE : S_SRD;
            S_DONE: if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_base   <= '0;
            r_count  <= '0;
            r_wvalid <= '0;
            r_mark   <= 1'b0;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_count <= ID_W'(r_count + 1'b1);
                r_last  <= i_last_item;
                r_mark  <= 1'b0;
                if (r_count == '0) begin
                    r_base   <= i_id_value;
                    r_wvalid <= '0;
                end else if (r_count < ID_W'(MAP_BITS)) begin
                    r_mark <= off_in_map;
                end
            end
            if (ram_we) begin
                r_wvalid[r_mword] <= 1'b1;
            end
            if (load_out) begin
                r_count  <= '0;
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mword <= off_word[WAW-1:0];
            r_mbit  <= off[WORD_SHIFT-1:0];
        end
        if (r_state == S_INIT) begin
            r_word      <= '0;
            r_last_word <= WAW'(bound_m1 >> WORD_SHIFT);
            r_last_bit  <= bound_m1[WORD_SHIFT-1:0];
            r_res       <= ID_W'(r_base + r_count);
        end
        if (r_state == S_SCK) begin
            if (found) begin
                r_res <= ID_W'(r_base + hole_off);
            end else begin
                r_word <= WAW'(r_word + 1'b1);
            end
        end
        if (load_out) begin
            r_out <= r_res;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_hole_value = r_out;

    // scan never runs past the last word in bound
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCK) |-> (r_word <= r_last_word))
        else $error("scan word past bound");

    // a marked word is flagged valid right after its write
    a_mark_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_wvalid[$past(r_mword)])
        else $error("marked word not flagged valid");

    // results appear only from the handoff state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside handoff");

    // a finished set always restarts with a new base
    a_count_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_count == '0) && (r_state == S_IDLE))
        else $error("count not cleared after result");

endmodule

`default_nettype wire
